// ----- hw/rtl/i2cbe_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cbe_pkg
// Types, constants and sequencer microcode tables for the I2C bit engine.
// ----------------------------------------------------------------------------
package i2cbe_pkg;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned InDataW    = 16;
  localparam int unsigned InUserW    = 3;
  localparam int unsigned OutDataW   = 16;
  localparam int unsigned CfgAddrW   = 3;
  localparam int unsigned CfgDataW   = 32;

  localparam logic [15:0] HalfPeriodReset = 16'd2;
  localparam logic [7:0]  AckPollReset    = 8'd250;

  typedef enum logic [0:0] {
    REG_HALF_PERIOD = 1'b0,
    REG_ACK_POLL    = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    CMD_TICK  = 3'd0,
    CMD_START = 3'd1,
    CMD_STOP  = 3'd2,
    CMD_WRITE = 3'd3,
    CMD_WAIT  = 3'd4,
    CMD_READ  = 3'd5,
    CMD_ACK   = 3'd6,
    CMD_NACK  = 3'd7
  } cmd_t;

  typedef enum logic [2:0] {
    OP_SCL0   = 3'd0,
    OP_SCL1   = 3'd1,
    OP_SDA0   = 3'd2,
    OP_SDA1   = 3'd3,
    OP_BIT    = 3'd4,
    OP_SAMP   = 3'd5,
    OP_POLL   = 3'd6,
    OP_ACKBIT = 3'd7
  } op_t;

  typedef enum logic [4:0] {
    PH_IDLE       = 5'd0,
    PH_ST_SDA1    = 5'd1,
    PH_ST_SCL1    = 5'd2,
    PH_ST_SDA0    = 5'd3,
    PH_ST_SCL0    = 5'd4,
    PH_SP_SCL0    = 5'd5,
    PH_SP_SDA0    = 5'd6,
    PH_SP_SCL1    = 5'd7,
    PH_SP_SDA1    = 5'd8,
    PH_WR_SCL0    = 5'd9,
    PH_WR_BIT     = 5'd10,
    PH_WR_SCL1    = 5'd11,
    PH_WR_SCL0B   = 5'd12,
    PH_WA_SDA1    = 5'd13,
    PH_WA_SCL1    = 5'd14,
    PH_WA_POLL    = 5'd15,
    PH_WA_SCL0    = 5'd16,
    PH_RD_SDA1    = 5'd17,
    PH_RD_SCL0    = 5'd18,
    PH_RD_SCL1    = 5'd19,
    PH_RD_SAMP    = 5'd20,
    PH_AK_SCL0    = 5'd21,
    PH_AK_BIT     = 5'd22,
    PH_AK_SCL1    = 5'd23,
    PH_AK_SCL0B   = 5'd24
  } phase_t;

  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] tx_byte;
    logic       ack_after_read;
    logic       sda_level;
  } item_t;

  typedef struct packed {
    logic       cmd_rejected;
    logic       ack_missing;
    logic [7:0] rx_byte;
    logic       done_res;
    logic       busy_res;
    logic       sda_release;
    logic       scl_release;
  } result_t;

  function automatic op_t prog_op(input phase_t ph);
    op_t op;
    case (ph)
      PH_IDLE:     op = OP_SCL0;
      PH_ST_SDA1:  op = OP_SDA1;
      PH_ST_SCL1:  op = OP_SCL1;
      PH_ST_SDA0:  op = OP_SDA0;
      PH_ST_SCL0:  op = OP_SCL0;
      PH_SP_SCL0:  op = OP_SCL0;
      PH_SP_SDA0:  op = OP_SDA0;
      PH_SP_SCL1:  op = OP_SCL1;
      PH_SP_SDA1:  op = OP_SDA1;
      PH_WR_SCL0:  op = OP_SCL0;
      PH_WR_BIT:   op = OP_BIT;
      PH_WR_SCL1:  op = OP_SCL1;
      PH_WR_SCL0B: op = OP_SCL0;
      PH_WA_SDA1:  op = OP_SDA1;
      PH_WA_SCL1:  op = OP_SCL1;
      PH_WA_POLL:  op = OP_POLL;
      PH_WA_SCL0:  op = OP_SCL0;
      PH_RD_SDA1:  op = OP_SDA1;
      PH_RD_SCL0:  op = OP_SCL0;
      PH_RD_SCL1:  op = OP_SCL1;
      PH_RD_SAMP:  op = OP_SAMP;
      PH_AK_SCL0:  op = OP_SCL0;
      PH_AK_BIT:   op = OP_ACKBIT;
      PH_AK_SCL1:  op = OP_SCL1;
      PH_AK_SCL0B: op = OP_SCL0;
      default:     op = OP_SCL0;
    endcase
    return op;
  endfunction

  // 1: the step is followed by a bus delay
  function automatic logic prog_dly(input phase_t ph);
    logic d;
    case (ph)
      PH_ST_SCL1, PH_ST_SDA0, PH_SP_SDA0, PH_SP_SDA1,
      PH_WR_SCL1, PH_WR_SCL0B, PH_WA_SDA1, PH_WA_SCL1,
      PH_RD_SCL0, PH_RD_SAMP, PH_AK_BIT, PH_AK_SCL1: d = 1'b1;
      default: d = 1'b0;
    endcase
    return d;
  endfunction

endpackage

// ----- hw/rtl/i2c_master_bit_engine.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_master_bit_engine
// I2C master bit engine: start, stop, byte write/read, ack wait and ack/nack.
// ----------------------------------------------------------------------------
// Each input item is one bus tick and yields exactly one result item with the
// SCL/SDA release levels and status after that tick. Throughput is one item
// per clock; the result of an item passes through the two-entry input queue,
// then the sequencer's output register. The sequencer state update, applied
// once per tick, sets that rate; a held result stalls the sequencer and the
// queue.
// Registers: 0x0 half_period_ticks, 0x4 ack_poll_limit.
// ----------------------------------------------------------------------------
module i2c_master_bit_engine #(
  parameter int unsigned DELAY_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [7:0] tx_byte, [8] ack_after_read, [9] sda_level
  input  logic [i2cbe_pkg::InDataW-1:0]     in_tdata,
  // [2:0] req_type
  input  logic [i2cbe_pkg::InUserW-1:0]     in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [0] scl_release, [1] sda_release, [2] busy_res, [3] done_res,
  // [11:4] rx_byte, [12] ack_missing, [13] cmd_rejected
  output logic [i2cbe_pkg::OutDataW-1:0]    out_tdata,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [i2cbe_pkg::CfgAddrW-1:0]    cfg_paddr,
  input  logic [i2cbe_pkg::CfgDataW-1:0]    cfg_pwdata,
  output logic [i2cbe_pkg::CfgDataW-1:0]    cfg_prdata,
  output logic                              cfg_pready
);

  logic [15:0]           half_period_r;
  logic [7:0]            ack_poll_r;
  logic                  cfg_wr;
  i2cbe_pkg::reg_idx_t   reg_idx;
  logic                  q_valid;
  logic                  q_pop;
  i2cbe_pkg::item_t      q_item;

  assign cfg_pready = 1'b1;
  assign reg_idx    = i2cbe_pkg::reg_idx_t'(cfg_paddr[2]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_period_r <= i2cbe_pkg::HalfPeriodReset;
      ack_poll_r    <= i2cbe_pkg::AckPollReset;
    end else if (cfg_wr) begin
      case (reg_idx)
        i2cbe_pkg::REG_HALF_PERIOD: half_period_r <= cfg_pwdata[15:0];
        i2cbe_pkg::REG_ACK_POLL:    ack_poll_r    <= cfg_pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      i2cbe_pkg::REG_HALF_PERIOD: cfg_prdata = {16'd0, half_period_r};
      i2cbe_pkg::REG_ACK_POLL:    cfg_prdata = {24'd0, ack_poll_r};
      default:                    cfg_prdata = '0;
    endcase
  end

  i2cbe_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_item    (q_item)
  );

  i2cbe_back #(
    .DELAY_BITS (DELAY_BITS)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (q_valid),
    .q_pop             (q_pop),
    .q_item            (q_item),
    .half_period_ticks (half_period_r),
    .ack_poll_limit    (ack_poll_r),
    .out_tvalid        (out_tvalid),
    .out_tready        (out_tready),
    .out_tdata         (out_tdata)
  );

endmodule

// ----- hw/rtl/i2cbe_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cbe_front
// Accepts input items, decodes the request type and holds them in a short
// queue for the sequencer.
// ----------------------------------------------------------------------------
module i2cbe_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [i2cbe_pkg::InDataW-1:0]     in_tdata,
  input  logic [i2cbe_pkg::InUserW-1:0]     in_tuser,
  output logic                              q_valid,
  input  logic                              q_pop,
  output i2cbe_pkg::item_t                  q_item
);

  localparam int unsigned PtrW = $clog2(i2cbe_pkg::QueueDepth);
  localparam int unsigned CntW = $clog2(i2cbe_pkg::QueueDepth + 1);

  i2cbe_pkg::item_t slot_r [i2cbe_pkg::QueueDepth];
  logic [PtrW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]  count_r, count_nxt;
  i2cbe_pkg::item_t item;
  logic             push;
  logic             pop;

  always_comb begin
    item.cmd            = i2cbe_pkg::cmd_t'(in_tuser);
    item.tx_byte        = in_tdata[7:0];
    item.ack_after_read = in_tdata[8];
    item.sda_level      = in_tdata[9];
  end

  assign in_tready = (count_r != CntW'(i2cbe_pkg::QueueDepth));
  assign q_valid   = (count_r != '0);
  assign q_item    = slot_r[rd_ptr_r];
  assign push      = in_tvalid && in_tready;
  assign pop       = q_pop && q_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(i2cbe_pkg::QueueDepth - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(i2cbe_pkg::QueueDepth - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= item;
    end
  end

endmodule

// ----- hw/rtl/i2cbe_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cbe_back
// Bus sequencer: runs one tick per queued item and registers the result.
// ----------------------------------------------------------------------------
module i2cbe_back #(
  parameter int unsigned DELAY_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              q_valid,
  output logic                              q_pop,
  input  i2cbe_pkg::item_t                  q_item,
  input  logic [15:0]                       half_period_ticks,
  input  logic [7:0]                        ack_poll_limit,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [i2cbe_pkg::OutDataW-1:0]    out_tdata
);

  localparam logic [32:0] DelayCap = (33'd1 << DELAY_BITS) - 33'd1;

  i2cbe_pkg::phase_t     phase_r, phase_nxt;
  logic [3:0]            bit_count_r, bit_count_nxt;
  logic [7:0]            shift_r, shift_nxt;
  logic [DELAY_BITS-1:0] delay_r, delay_nxt;
  logic [7:0]            poll_r, poll_nxt;
  logic                  scl_r, scl_nxt;
  logic                  sda_r, sda_nxt;
  logic                  ack_choice_r, ack_choice_nxt;
  logic                  ack_flag_r, ack_flag_nxt;
  logic [7:0]            rx_r, rx_nxt;
  logic                  out_valid_r;
  i2cbe_pkg::result_t    out_data_r;
  i2cbe_pkg::result_t    res;
  logic                  done;
  logic                  rejected;
  logic                  adv;
  i2cbe_pkg::op_t        op;
  logic [15:0]           h_nz;
  logic [DELAY_BITS-1:0] eff_delay;

  always_comb begin
    h_nz = (half_period_ticks == 16'd0) ? 16'd1 : half_period_ticks;
    if ({17'd0, h_nz} > DelayCap) begin
      eff_delay = DelayCap[DELAY_BITS-1:0];
    end else begin
      eff_delay = DELAY_BITS'(h_nz);
    end
  end

  assign q_pop = q_valid && (!out_valid_r || out_tready);

  // next state
  always_comb begin
    phase_nxt      = phase_r;
    bit_count_nxt  = bit_count_r;
    shift_nxt      = shift_r;
    delay_nxt      = delay_r;
    poll_nxt       = poll_r;
    scl_nxt        = scl_r;
    sda_nxt        = sda_r;
    ack_choice_nxt = ack_choice_r;
    ack_flag_nxt   = ack_flag_r;
    rx_nxt         = rx_r;
    done           = 1'b0;
    rejected       = 1'b0;
    adv            = 1'b0;
    op             = i2cbe_pkg::OP_SCL0;

    if (phase_r == i2cbe_pkg::PH_IDLE) begin
      delay_nxt = '0;
      case (q_item.cmd)
        i2cbe_pkg::CMD_START: phase_nxt = i2cbe_pkg::PH_ST_SDA1;
        i2cbe_pkg::CMD_STOP:  phase_nxt = i2cbe_pkg::PH_SP_SCL0;
        i2cbe_pkg::CMD_WRITE: begin
          phase_nxt     = i2cbe_pkg::PH_WR_SCL0;
          shift_nxt     = q_item.tx_byte;
          bit_count_nxt = 4'd8;
        end
        i2cbe_pkg::CMD_WAIT: begin
          phase_nxt    = i2cbe_pkg::PH_WA_SDA1;
          poll_nxt     = 8'd0;
          ack_flag_nxt = 1'b0;
        end
        i2cbe_pkg::CMD_READ: begin
          phase_nxt      = i2cbe_pkg::PH_RD_SDA1;
          shift_nxt      = 8'd0;
          bit_count_nxt  = 4'd8;
          ack_choice_nxt = q_item.ack_after_read;
        end
        i2cbe_pkg::CMD_ACK: begin
          phase_nxt      = i2cbe_pkg::PH_AK_SCL0;
          ack_choice_nxt = 1'b1;
        end
        i2cbe_pkg::CMD_NACK: begin
          phase_nxt      = i2cbe_pkg::PH_AK_SCL0;
          ack_choice_nxt = 1'b0;
        end
        default: ;
      endcase
    end else if (q_item.cmd != i2cbe_pkg::CMD_TICK) begin
      rejected = 1'b1;
    end

    if (phase_nxt != i2cbe_pkg::PH_IDLE) begin
      if (delay_nxt != '0) begin
        delay_nxt = delay_nxt - 1'b1;
        adv       = (delay_nxt == '0);
      end else begin
        op = i2cbe_pkg::prog_op(phase_nxt);
        case (op)
          i2cbe_pkg::OP_POLL: begin
            if (!q_item.sda_level) begin
              phase_nxt = i2cbe_pkg::PH_WA_SCL0;
            end else if ({1'b0, poll_nxt} + 9'd1 > {1'b0, ack_poll_limit}) begin
              ack_flag_nxt = 1'b1;
              phase_nxt    = i2cbe_pkg::PH_SP_SCL0;
            end else begin
              poll_nxt = poll_nxt + 8'd1;
            end
          end
          i2cbe_pkg::OP_SCL0: scl_nxt = 1'b0;
          i2cbe_pkg::OP_SCL1: scl_nxt = 1'b1;
          i2cbe_pkg::OP_SDA0: sda_nxt = 1'b0;
          i2cbe_pkg::OP_SDA1: sda_nxt = 1'b1;
          i2cbe_pkg::OP_BIT: begin
            sda_nxt   = shift_nxt[7];
            shift_nxt = {shift_nxt[6:0], 1'b0};
            if (bit_count_nxt != 4'd0) bit_count_nxt = bit_count_nxt - 4'd1;
          end
          i2cbe_pkg::OP_SAMP: begin
            shift_nxt = {shift_nxt[6:0], q_item.sda_level};
            if (bit_count_nxt != 4'd0) bit_count_nxt = bit_count_nxt - 4'd1;
          end
          default: sda_nxt = !ack_choice_nxt;
        endcase
        if (op != i2cbe_pkg::OP_POLL) begin
          if (i2cbe_pkg::prog_dly(phase_nxt)) begin
            delay_nxt = eff_delay;
          end else begin
            adv = 1'b1;
          end
        end
      end
    end

    if (adv) begin
      case (phase_nxt)
        i2cbe_pkg::PH_ST_SCL0, i2cbe_pkg::PH_SP_SDA1,
        i2cbe_pkg::PH_WA_SCL0, i2cbe_pkg::PH_AK_SCL0B: begin
          phase_nxt = i2cbe_pkg::PH_IDLE;
          done      = 1'b1;
        end
        i2cbe_pkg::PH_WR_SCL0B: begin
          if (bit_count_nxt != 4'd0) begin
            phase_nxt = i2cbe_pkg::PH_WR_BIT;
          end else begin
            phase_nxt = i2cbe_pkg::PH_IDLE;
            done      = 1'b1;
          end
        end
        i2cbe_pkg::PH_RD_SAMP: begin
          if (bit_count_nxt != 4'd0) begin
            phase_nxt = i2cbe_pkg::PH_RD_SCL0;
          end else begin
            rx_nxt    = shift_nxt;
            phase_nxt = i2cbe_pkg::PH_AK_SCL0;
          end
        end
        default: phase_nxt = i2cbe_pkg::phase_t'(phase_nxt + 5'd1);
      endcase
    end
  end

  // result fields
  always_comb begin
    res.scl_release  = scl_nxt;
    res.sda_release  = sda_nxt;
    res.busy_res     = (phase_nxt != i2cbe_pkg::PH_IDLE);
    res.done_res     = done;
    res.rx_byte      = rx_nxt;
    res.ack_missing  = ack_flag_nxt;
    res.cmd_rejected = rejected;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= i2cbe_pkg::PH_IDLE;
      bit_count_r  <= '0;
      shift_r      <= '0;
      delay_r      <= '0;
      poll_r       <= '0;
      scl_r        <= 1'b1;
      sda_r        <= 1'b1;
      ack_choice_r <= 1'b0;
      ack_flag_r   <= 1'b0;
      rx_r         <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (q_pop) begin
        phase_r      <= phase_nxt;
        bit_count_r  <= bit_count_nxt;
        shift_r      <= shift_nxt;
        delay_r      <= delay_nxt;
        poll_r       <= poll_nxt;
        scl_r        <= scl_nxt;
        sda_r        <= sda_nxt;
        ack_choice_r <= ack_choice_nxt;
        ack_flag_r   <= ack_flag_nxt;
        rx_r         <= rx_nxt;
        out_valid_r  <= 1'b1;
      end else if (out_tready) begin
        out_valid_r  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_data_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(i2cbe_pkg::OutDataW - $bits(i2cbe_pkg::result_t)){1'b0}}, out_data_r};

endmodule

// ----- tb/i2c_master_bit_engine_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_master_bit_engine_checker
// Watches the tick, line-state and register channels of the I2C bit engine.
// It runs its own model of the bus sequencer on every accepted tick, queues
// the expected SCL/SDA levels and status, and compares each line-state item
// that leaves the engine with the oldest expected one.
// ----------------------------------------------------------------------------
module i2c_master_bit_engine_checker
  import i2cbe_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  input  logic                in_tready,
  input  logic [InDataW-1:0]  in_tdata,
  input  logic [InUserW-1:0]  in_tuser,
  input  logic                out_tvalid,
  input  logic                out_tready,
  input  logic [OutDataW-1:0] out_tdata,
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic                cfg_pready,
  input  logic [CfgAddrW-1:0] cfg_paddr,
  input  logic [CfgDataW-1:0] cfg_pwdata,
  output int                  n_fail,
  output int                  n_pending,
  output int                  n_checked,
  output logic                seq_busy
);

  logic [15:0] half_ticks;
  logic [7:0]  poll_limit;
  phase_t      ph;
  logic [3:0]  bits_left;
  logic [7:0]  shreg;
  logic [15:0] dly_left;
  logic [7:0]  polls;
  logic        scl_rel;
  logic        sda_rel;
  logic        send_ack;
  logic        ack_miss;
  logic        seq_done;
  logic [7:0]  rx_held;
  result_t     lines_due[$];
  int          n_bad;
  int          n_seen;

  task automatic next_phase();
    case (ph)
      PH_WR_SCL0B: ph = (bits_left != 4'd0) ? PH_WR_BIT : PH_IDLE;
      PH_RD_SAMP: begin
        if (bits_left != 4'd0) begin
          ph = PH_RD_SCL0;
        end else begin
          rx_held = shreg;
          ph = PH_AK_SCL0;
        end
      end
      PH_ST_SCL0, PH_SP_SDA1, PH_WA_SCL0, PH_AK_SCL0B: ph = PH_IDLE;
      default: ph = phase_t'(ph + 5'd1);
    endcase
    if (ph == PH_IDLE) seq_done = 1'b1;
  endtask

  // One bus tick: start a command if idle, then count down a delay or run a step
  task automatic predict_lines(input item_t it, output result_t r);
    logic rejected;
    rejected = 1'b0;
    seq_done = 1'b0;
    if (ph == PH_IDLE) begin
      dly_left = '0;
      case (it.cmd)
        CMD_START: ph = PH_ST_SDA1;
        CMD_STOP:  ph = PH_SP_SCL0;
        CMD_WRITE: begin
          ph = PH_WR_SCL0;
          shreg = it.tx_byte;
          bits_left = 4'd8;
        end
        CMD_WAIT: begin
          ph = PH_WA_SDA1;
          polls = '0;
          ack_miss = 1'b0;
        end
        CMD_READ: begin
          ph = PH_RD_SDA1;
          shreg = '0;
          bits_left = 4'd8;
          send_ack = it.ack_after_read;
        end
        CMD_ACK: begin
          ph = PH_AK_SCL0;
          send_ack = 1'b1;
        end
        CMD_NACK: begin
          ph = PH_AK_SCL0;
          send_ack = 1'b0;
        end
        default: ;
      endcase
    end else if (it.cmd != CMD_TICK) begin
      rejected = 1'b1;
    end

    if (ph != PH_IDLE) begin
      if (dly_left != '0) begin
        dly_left = dly_left - 16'd1;
        if (dly_left == '0) next_phase();
      end else if (ph == PH_WA_POLL) begin
        if (!it.sda_level) begin
          ph = PH_WA_SCL0;
        end else if ({1'b0, polls} + 9'd1 > {1'b0, poll_limit}) begin
          ack_miss = 1'b1;
          ph = PH_SP_SCL0;
        end else begin
          polls = polls + 8'd1;
        end
      end else begin
        case (ph)
          PH_ST_SDA1, PH_SP_SDA1, PH_WA_SDA1, PH_RD_SDA1: sda_rel = 1'b1;
          PH_ST_SDA0, PH_SP_SDA0: sda_rel = 1'b0;
          PH_ST_SCL1, PH_SP_SCL1, PH_WR_SCL1, PH_WA_SCL1, PH_RD_SCL1,
          PH_AK_SCL1: scl_rel = 1'b1;
          PH_WR_BIT: begin
            sda_rel = shreg[7];
            shreg = shreg << 1;
            if (bits_left != 4'd0) bits_left = bits_left - 4'd1;
          end
          PH_RD_SAMP: begin
            shreg = {shreg[6:0], it.sda_level};
            if (bits_left != 4'd0) bits_left = bits_left - 4'd1;
          end
          PH_AK_BIT: sda_rel = ~send_ack;
          default: scl_rel = 1'b0;
        endcase
        case (ph)
          PH_ST_SCL1, PH_ST_SDA0, PH_SP_SDA0, PH_SP_SDA1, PH_WR_SCL1, PH_WR_SCL0B,
          PH_WA_SDA1, PH_WA_SCL1, PH_RD_SCL0, PH_RD_SAMP, PH_AK_BIT,
          PH_AK_SCL1: dly_left = (half_ticks == 16'd0) ? 16'd1 : half_ticks;
          default: next_phase();
        endcase
      end
    end

    r.scl_release  = scl_rel;
    r.sda_release  = sda_rel;
    r.busy_res     = (ph != PH_IDLE);
    r.done_res     = seq_done;
    r.rx_byte      = rx_held;
    r.ack_missing  = ack_miss;
    r.cmd_rejected = rejected;
  endtask

  always @(posedge clk) begin
    item_t   taken;
    result_t want;
    result_t got;
    if (!rst_n) begin
      half_ticks = HalfPeriodReset;
      poll_limit = AckPollReset;
      ph         = PH_IDLE;
      bits_left  = '0;
      shreg      = '0;
      dly_left   = '0;
      polls      = '0;
      scl_rel    = 1'b1;
      sda_rel    = 1'b1;
      send_ack   = 1'b0;
      ack_miss   = 1'b0;
      seq_done   = 1'b0;
      rx_held    = '0;
      n_bad      = 0;
      n_seen     = 0;
      lines_due.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (reg_idx_t'(cfg_paddr[2]))
          REG_HALF_PERIOD: half_ticks = cfg_pwdata[15:0];
          REG_ACK_POLL:    poll_limit = cfg_pwdata[7:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        taken.cmd            = cmd_t'(in_tuser);
        taken.tx_byte        = in_tdata[7:0];
        taken.ack_after_read = in_tdata[8];
        taken.sda_level      = in_tdata[9];
        predict_lines(taken, want);
        lines_due.push_back(want);
      end
      if (out_tvalid && out_tready) begin
        got = result_t'(out_tdata[13:0]);
        if (lines_due.size() == 0) begin
          if (n_bad < 10)
            $display("line state %0d arrived with none expected: %h", n_seen, got);
          n_bad++;
        end else begin
          want = lines_due.pop_front();
          if (got !== want) begin
            if (n_bad < 10) begin
              $display("line state %0d want: scl=%b sda=%b busy=%b done=%b rx=%h miss=%b rej=%b",
                       n_seen, want.scl_release, want.sda_release, want.busy_res,
                       want.done_res, want.rx_byte, want.ack_missing, want.cmd_rejected);
              $display("line state %0d got:  scl=%b sda=%b busy=%b done=%b rx=%h miss=%b rej=%b",
                       n_seen, got.scl_release, got.sda_release, got.busy_res,
                       got.done_res, got.rx_byte, got.ack_missing, got.cmd_rejected);
            end
            n_bad++;
          end
        end
        n_seen++;
      end
    end
    n_fail    <= n_bad;
    n_pending <= lines_due.size();
    n_checked <= n_seen;
    seq_busy  <= (ph != PH_IDLE);
  end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the I2C master bit engine.
// Directed commands under the reset register values, then random transfers
// (start, address write, ack wait, writes and reads, stop) with stray commands
// while busy, over several half-period and poll-limit settings including a zero
// half period and both poll-limit extremes, with random idling on both
// channels and a long result hold-off, and a start under a long half period.
// ----------------------------------------------------------------------------
module tb;
  import i2cbe_pkg::*;

  localparam int CycleLimit = 2_000_000;
  localparam int LongHold   = 48;
  localparam int NoAck      = 100000;

  logic                clk         = 1'b0;
  logic                rst_n       = 1'b0;
  logic                in_tvalid   = 1'b0;
  logic                in_tready;
  logic [InDataW-1:0]  in_tdata    = '0;
  logic [InUserW-1:0]  in_tuser    = '0;
  logic                out_tvalid;
  logic                out_tready  = 1'b0;
  logic [OutDataW-1:0] out_tdata;
  logic                cfg_psel    = 1'b0;
  logic                cfg_penable = 1'b0;
  logic                cfg_pwrite  = 1'b0;
  logic [CfgAddrW-1:0] cfg_paddr   = '0;
  logic [CfgDataW-1:0] cfg_pwdata  = '0;
  logic [CfgDataW-1:0] cfg_prdata;
  logic                cfg_pready;

  int   n_fail;
  int   n_pending;
  int   n_checked;
  logic seq_busy;

  int cycles     = 0;
  int n_items    = 0;
  int n_cmds     = 0;
  int n_settings = 0;
  int hold_seq   = 0;
  bit idle_on    = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  i2c_master_bit_engine i_dut (.*);

  i2c_master_bit_engine_checker i_checker (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("Timed out after %0d cycles", cycles);
      $display("i2c_master_bit_engine test failed");
      $finish;
    end
  end

  // result side: short random stalls, and a long hold-off on request
  initial begin
    int hold_seen;
    hold_seen = 0;
    forever begin
      @(posedge clk);
      if (hold_seq != hold_seen) begin
        hold_seen = hold_seq;
        out_tready <= 1'b0;
        repeat (LongHold) @(posedge clk);
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  task automatic send_item(input cmd_t c, input logic [7:0] tx, input logic ackr,
                           input logic sda);
    in_tvalid <= 1'b1;
    in_tuser  <= c;
    in_tdata  <= {6'd0, sda, ackr, tx};
    do @(posedge clk); while (!in_tready);
    n_items++;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
  endtask

  // ack_high: ticks SDA stays high before the slave pulls it low; negative: random SDA
  task automatic run_cmd(input cmd_t c, input logic [7:0] tx, input logic ackr,
                         input int ack_high, input bit noisy);
    int   n;
    cmd_t stray;
    logic sda;
    n = 0;
    if (c != CMD_TICK) n_cmds++;
    send_item(c, tx, ackr, 1'($urandom));
    do begin
      stray = CMD_TICK;
      if (noisy && $urandom_range(0, 9) == 0) stray = cmd_t'($urandom_range(1, 7));
      sda = (ack_high < 0) ? 1'($urandom_range(0, 1)) : (n < ack_high);
      send_item(stray, 8'($urandom), 1'($urandom), sda);
      n++;
    end while (seq_busy);
  endtask

  task automatic cfg_write(input reg_idx_t idx, input logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [15:0] half, input logic [7:0] limit);
    run_cmd(CMD_TICK, 8'h00, 1'b0, -1, 1'b0);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (n_pending != 0) @(posedge clk);
    cfg_write(REG_HALF_PERIOD, {16'd0, half});
    cfg_write(REG_ACK_POLL, {24'd0, limit});
    n_settings++;
  endtask

  function automatic int ack_stretch();
    return ($urandom_range(0, 9) == 0) ? NoAck : int'($urandom_range(0, 3));
  endfunction

  task automatic random_traffic(input int quota);
    int   stop_at;
    cmd_t c;
    stop_at = n_items + quota;
    while (n_items < stop_at) begin
      if ($urandom_range(0, 4) != 0) begin
        run_cmd(CMD_START, 8'($urandom), 1'($urandom), -1, 1'b1);
        run_cmd(CMD_WRITE, 8'($urandom), 1'($urandom), -1, 1'b1);
        run_cmd(CMD_WAIT, 8'($urandom), 1'($urandom), ack_stretch(), 1'b1);
        repeat ($urandom_range(1, 3)) begin
          if ($urandom_range(0, 1) != 0) begin
            run_cmd(CMD_WRITE, 8'($urandom), 1'($urandom), -1, 1'b1);
            run_cmd(CMD_WAIT, 8'($urandom), 1'($urandom), ack_stretch(), 1'b1);
          end else begin
            run_cmd(CMD_READ, 8'($urandom), 1'($urandom), -1, 1'b1);
          end
        end
        run_cmd(CMD_STOP, 8'($urandom), 1'($urandom), -1, 1'b1);
      end else begin
        c = cmd_t'($urandom_range(0, 7));
        run_cmd(c, 8'($urandom), 1'($urandom), (c == CMD_WAIT) ? ack_stretch() : -1, 1'b1);
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed, reset register values
    run_cmd(CMD_TICK, 8'h00, 1'b0, 0, 1'b0);
    run_cmd(CMD_STOP, 8'hFF, 1'b1, -1, 1'b0);
    run_cmd(CMD_START, 8'h00, 1'b0, -1, 1'b0);
    run_cmd(CMD_WRITE, 8'hFF, 1'b0, -1, 1'b0);
    run_cmd(CMD_WAIT, 8'h00, 1'b0, 0, 1'b0);
    run_cmd(CMD_WRITE, 8'h00, 1'b1, -1, 1'b0);
    run_cmd(CMD_WAIT, 8'h00, 1'b0, NoAck, 1'b0);
    run_cmd(CMD_WAIT, 8'hFF, 1'b1, 3, 1'b0);
    run_cmd(CMD_READ, 8'h5A, 1'b1, -1, 1'b0);
    run_cmd(CMD_READ, 8'hA5, 1'b0, -1, 1'b0);
    run_cmd(CMD_ACK, 8'h00, 1'b0, -1, 1'b0);
    run_cmd(CMD_NACK, 8'hFF, 1'b1, -1, 1'b0);
    // every command but tick and start offered while a start is still running
    send_item(CMD_START, 8'h00, 1'b0, 1'b1);
    for (int c = CMD_STOP; c <= CMD_NACK; c++) send_item(cmd_t'(c), 8'hA5, 1'b1, 1'b0);
    run_cmd(CMD_TICK, 8'h00, 1'b0, -1, 1'b0);
    run_cmd(CMD_STOP, 8'h00, 1'b0, -1, 1'b0);

    idle_on = 1'b1;
    set_config(16'd1, 8'd0);
    random_traffic(350);

    set_config(16'd0, 8'd255);
    hold_seq++;
    random_traffic(350);

    idle_on = 1'b0;
    set_config(16'd100, 8'd250);
    run_cmd(CMD_START, 8'h00, 1'b0, -1, 1'b0);

    idle_on = 1'b1;
    set_config(16'd3, 8'd2);
    hold_seq++;
    random_traffic(350);

    idle_on = 1'b0;
    set_config(16'd2, 8'd7);
    random_traffic(350);

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (n_pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Sent %0d ticks with %0d commands under %0d register settings; %0d results checked",
             n_items, n_cmds, n_settings + 1, n_checked);
    $display("Covered all commands, ack timeouts, busy rejects, zero and long half periods");
    if (n_fail == 0 && n_pending == 0) begin
      $display("i2c_master_bit_engine test passed");
    end else begin
      $display("i2c_master_bit_engine test failed");
    end
    $finish;
  end

endmodule
